@@ hw/rtl/lgpl_pkg.sv @@
// ----------------------------------------------------------------------------
// lgpl_pkg
// shared constants, codes and the result word of the link gene parent limiter
// ----------------------------------------------------------------------------
package lgpl_pkg;

    localparam int MAX_NODES_DEF = 32;

    localparam int NODE_FIELD_W  = 5;
    localparam int COUNT_W       = 5;
    localparam int GENE_W        = 2;
    localparam int CFG_DATA_W    = 6;
    localparam int CFG_INDEX_W   = 1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

    // gene codes
    localparam logic [GENE_W-1:0] GENE_NONE = 2'd0;
    localparam logic [GENE_W-1:0] GENE_FWD  = 2'd1;
    localparam logic [GENE_W-1:0] GENE_REV  = 2'd2;
    localparam logic [GENE_W-1:0] GENE_BAD  = 2'd3;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_NODE_COUNT  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_PARENTS = 1'd1;

    localparam logic [CFG_DATA_W-1:0] NODE_COUNT_RST  = 6'd32;
    localparam logic [COUNT_W-1:0]    MAX_PARENTS_RST = 5'd0;

    typedef struct packed {
        logic [NODE_FIELD_W-1:0] from_node;
        logic [NODE_FIELD_W-1:0] to_node;
        logic [GENE_W-1:0]       link_out;
        logic                    edge_added;
        logic                    edge_dropped;
        logic [COUNT_W-1:0]      target_parent_count;
        logic [COUNT_W-1:0]      source_child_count;
        logic                    bad_item;
        logic                    last_pair;
    } lgpl_result_t;

endpackage

@@ hw/rtl/lgpl_count_mem.sv @@
// ----------------------------------------------------------------------------
// lgpl_count_mem
// per-node count memory with valid bits and two registered prefetch ports
// ----------------------------------------------------------------------------
module lgpl_count_mem
    import lgpl_pkg::*;
#(
    parameter int DEPTH = MAX_NODES_DEF,
    localparam int AW = $clog2(DEPTH)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               clear,
    input  logic               we,
    input  logic [AW-1:0]      waddr,
    input  logic [COUNT_W-1:0] wdata,
    input  logic [AW-1:0]      raddr_a,
    input  logic [AW-1:0]      raddr_b,
    output logic [COUNT_W-1:0] rval_a,
    output logic [COUNT_W-1:0] rval_b
);

    logic [COUNT_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]   valid_reg;
    logic [DEPTH-1:0]   valid_next;
    logic [COUNT_W-1:0] rd_a_reg;
    logic [COUNT_W-1:0] rd_b_reg;
    logic [COUNT_W-1:0] wdata_hold_reg;
    logic               hit_a_reg;
    logic               hit_b_reg;
    logic               live_a_reg;
    logic               live_b_reg;

    always_comb
    begin
        valid_next = clear ? '0 : valid_reg;
        if (we)
        begin
            valid_next[waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_a_reg       <= mem[raddr_a];
        rd_b_reg       <= mem[raddr_b];
        wdata_hold_reg <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            hit_a_reg  <= 1'b0;
            hit_b_reg  <= 1'b0;
            live_a_reg <= 1'b0;
            live_b_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            // write in the same cycle as the read: forward the new value
            hit_a_reg  <= we && (waddr == raddr_a);
            hit_b_reg  <= we && (waddr == raddr_b);
            live_a_reg <= valid_next[raddr_a];
            live_b_reg <= valid_next[raddr_b];
        end
    end

    assign rval_a = !live_a_reg ? '0 : (hit_a_reg ? wdata_hold_reg : rd_a_reg);
    assign rval_b = !live_b_reg ? '0 : (hit_b_reg ? wdata_hold_reg : rd_b_reg);

endmodule

@@ hw/rtl/lgpl_core.sv @@
// ----------------------------------------------------------------------------
// lgpl_core
// pair tracking, parent limit check and count update for one gene a cycle while fire is high
// ----------------------------------------------------------------------------
module lgpl_core
    import lgpl_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    localparam int NW = $clog2(MAX_NODES)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [CFG_DATA_W-1:0] node_count,
    input  logic [COUNT_W-1:0]    max_parents,
    input  logic                  fire,
    input  logic [GENE_W-1:0]     link_value,
    input  logic                  start_network,
    input  logic [COUNT_W-1:0]    par_lo,
    input  logic [COUNT_W-1:0]    par_hi,
    input  logic [COUNT_W-1:0]    chl_lo,
    input  logic [COUNT_W-1:0]    chl_hi,
    output logic [NW-1:0]         lo_next,
    output logic [NW-1:0]         hi_next,
    output logic                  clear,
    output logic                  par_we,
    output logic [NW-1:0]         par_waddr,
    output logic [COUNT_W-1:0]    par_wdata,
    output logic                  chl_we,
    output logic [NW-1:0]         chl_waddr,
    output logic [COUNT_W-1:0]    chl_wdata,
    output lgpl_result_t          res
);

    localparam int NCW = $clog2(MAX_NODES + 1);
    localparam int CW  = (NCW > CFG_DATA_W) ? NCW : CFG_DATA_W;

    logic [NW-1:0]      lo_reg;
    logic [NW-1:0]      hi_reg;
    logic               past_reg;
    logic               past_next;

    logic [CW-1:0]      nc_ext;
    logic [CW-1:0]      n_use;
    logic [NW-1:0]      lo;
    logic [NW-1:0]      hi;
    logic               past;
    logic               out_of_range;
    logic [NW-1:0]      src;
    logic [NW-1:0]      dst;
    logic [COUNT_W-1:0] pdst;
    logic [COUNT_W-1:0] csrc;
    logic [COUNT_W-1:0] pdst_new;
    logic [COUNT_W-1:0] csrc_new;
    logic               is_link;
    logic               drop;
    logic               add;
    logic [NW-1:0]      lo_adv;
    logic [NW-1:0]      hi_adv;
    logic               past_adv;
    logic               last;

    always_comb
    begin
        nc_ext = CW'(node_count);
        n_use  = nc_ext;
        if (nc_ext < CW'(2))
        begin
            n_use = CW'(2);
        end
        else if (nc_ext > CW'(MAX_NODES))
        begin
            n_use = CW'(MAX_NODES);
        end

        // a start word restarts at the first pair with all counts zero
        lo   = start_network ? '0 : lo_reg;
        hi   = start_network ? NW'(1) : hi_reg;
        past = start_network ? 1'b0 : past_reg;

        out_of_range = past || (CW'(hi) >= n_use) || (lo >= hi);

        src  = lo;
        dst  = hi;
        pdst = par_hi;
        csrc = chl_lo;
        if (link_value == GENE_REV)
        begin
            src  = hi;
            dst  = lo;
            pdst = par_lo;
            csrc = chl_hi;
        end
        if (start_network)
        begin
            pdst = '0;
            csrc = '0;
        end

        is_link  = (link_value == GENE_FWD) || (link_value == GENE_REV);
        drop     = is_link && (max_parents != '0) && (pdst >= max_parents);
        add      = is_link && !drop;
        pdst_new = (add && (pdst != COUNT_MAX)) ? pdst + COUNT_W'(1) : pdst;
        csrc_new = (add && (csrc != COUNT_MAX)) ? csrc + COUNT_W'(1) : csrc;

        lo_adv   = lo;
        hi_adv   = hi;
        past_adv = 1'b0;
        last     = 1'b0;
        if (CW'(hi) < (n_use - CW'(1)))
        begin
            hi_adv = hi + NW'(1);
        end
        else if (((CW+1)'(lo) + (CW+1)'(2)) >= (CW+1)'(n_use))
        begin
            last     = 1'b1;
            past_adv = 1'b1;
        end
        else
        begin
            lo_adv = lo + NW'(1);
            hi_adv = lo + NW'(2);
        end

        res = '0;
        if (out_of_range)
        begin
            res.bad_item = 1'b1;
        end
        else
        begin
            res.from_node           = NODE_FIELD_W'(src);
            res.to_node             = NODE_FIELD_W'(dst);
            res.link_out            = add ? link_value : GENE_NONE;
            res.edge_added          = add;
            res.edge_dropped        = drop;
            res.target_parent_count = pdst_new;
            res.source_child_count  = csrc_new;
            res.bad_item            = (link_value == GENE_BAD);
            res.last_pair           = last;
        end

        lo_next   = lo_reg;
        hi_next   = hi_reg;
        past_next = past_reg;
        if (fire)
        begin
            lo_next   = out_of_range ? lo : lo_adv;
            hi_next   = out_of_range ? hi : hi_adv;
            past_next = out_of_range ? 1'b1 : past_adv;
        end

        clear     = fire && start_network;
        par_we    = fire && !out_of_range && add;
        par_waddr = dst;
        par_wdata = pdst_new;
        chl_we    = fire && !out_of_range && add;
        chl_waddr = src;
        chl_wdata = csrc_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_reg   <= '0;
            hi_reg   <= NW'(1);
            past_reg <= 1'b0;
        end
        else
        begin
            lo_reg   <= lo_next;
            hi_reg   <= hi_next;
            past_reg <= past_next;
        end
    end

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        lo_reg < hi_reg)
        else $error("pair order broken");

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> !(res.edge_added && res.edge_dropped))
        else $error("edge both added and dropped");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.last_pair |=> past_reg)
        else $error("last pair did not end the network");

    a_past_bad: assert property (@(posedge clk) disable iff (!rst_n)
        fire && past_reg && !start_network |-> res.bad_item && !res.edge_added)
        else $error("word past the end not flagged");

endmodule

@@ hw/rtl/lgpl_out_buf.sv @@
// ----------------------------------------------------------------------------
// lgpl_out_buf
// result register with a skid stage; the input side waits only while the skid is full
// ----------------------------------------------------------------------------
module lgpl_out_buf
    import lgpl_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  lgpl_result_t push_data,
    input  logic         out_stall,
    output logic         out_valid,
    output lgpl_result_t out_data,
    output logic         full
);

    logic         out_valid_reg;
    logic         skid_valid_reg;
    lgpl_result_t out_data_reg;
    lgpl_result_t skid_data_reg;
    logic         pop;

    assign pop = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_data_reg <= push_data;
            end
            else
            begin
                out_data_reg <= push_data;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign full      = skid_valid_reg;

    a_skid_behind: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word without a head word");

endmodule

@@ hw/rtl/link_gene_parent_limiter.sv @@
// ----------------------------------------------------------------------------
// link_gene_parent_limiter
// limits parents per node over a stream of pairwise link genes
//
//  channel  handshake                  payload
//  input    in_valid / in_stall        link_value, start_network
//  output   out_valid / out_stall      from_node .. last_pair
//  config   cfg_write                  cfg_index, cfg_data
//
//  one word accepted per cycle while in_stall is low, its result registered in
//  the output or the skid stage; the rate is set by the count read-modify-write,
//  kept up by prefetching both counts of the coming pair from each count memory
//  in_stall is registered: it rises only when the skid stage holds a word
//  reset clears counts at once through per-node valid bits, no clearing pass
// ----------------------------------------------------------------------------
module link_gene_parent_limiter
    import lgpl_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [GENE_W-1:0]       link_value,
    input  logic                    start_network,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [NODE_FIELD_W-1:0] from_node,
    output logic [NODE_FIELD_W-1:0] to_node,
    output logic [GENE_W-1:0]       link_out,
    output logic                    edge_added,
    output logic                    edge_dropped,
    output logic [COUNT_W-1:0]      target_parent_count,
    output logic [COUNT_W-1:0]      source_child_count,
    output logic                    bad_item,
    output logic                    last_pair
);

    localparam int NW = $clog2(MAX_NODES);

    logic [CFG_DATA_W-1:0] node_count_reg;
    logic [COUNT_W-1:0]    max_parents_reg;
    logic                  fire;
    logic                  full;
    logic [NW-1:0]         lo_next;
    logic [NW-1:0]         hi_next;
    logic                  clear;
    logic                  par_we;
    logic [NW-1:0]         par_waddr;
    logic [COUNT_W-1:0]    par_wdata;
    logic                  chl_we;
    logic [NW-1:0]         chl_waddr;
    logic [COUNT_W-1:0]    chl_wdata;
    logic [COUNT_W-1:0]    par_lo;
    logic [COUNT_W-1:0]    par_hi;
    logic [COUNT_W-1:0]    chl_lo;
    logic [COUNT_W-1:0]    chl_hi;
    lgpl_result_t          res;
    lgpl_result_t          out_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg  <= NODE_COUNT_RST;
            max_parents_reg <= MAX_PARENTS_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_NODE_COUNT:  node_count_reg  <= cfg_data;
                REG_MAX_PARENTS: max_parents_reg <= cfg_data[COUNT_W-1:0];
                default:         node_count_reg  <= node_count_reg;
            endcase
        end
    end

    assign in_stall = full;
    assign fire     = in_valid && !in_stall;

    lgpl_core #(
        .MAX_NODES (MAX_NODES)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .node_count    (node_count_reg),
        .max_parents   (max_parents_reg),
        .fire          (fire),
        .link_value    (link_value),
        .start_network (start_network),
        .par_lo        (par_lo),
        .par_hi        (par_hi),
        .chl_lo        (chl_lo),
        .chl_hi        (chl_hi),
        .lo_next       (lo_next),
        .hi_next       (hi_next),
        .clear         (clear),
        .par_we        (par_we),
        .par_waddr     (par_waddr),
        .par_wdata     (par_wdata),
        .chl_we        (chl_we),
        .chl_waddr     (chl_waddr),
        .chl_wdata     (chl_wdata),
        .res           (res)
    );

    // parent counts, prefetched at both nodes of the coming pair
    lgpl_count_mem #(
        .DEPTH (MAX_NODES)
    ) u_parent_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (clear),
        .we      (par_we),
        .waddr   (par_waddr),
        .wdata   (par_wdata),
        .raddr_a (lo_next),
        .raddr_b (hi_next),
        .rval_a  (par_lo),
        .rval_b  (par_hi)
    );

    lgpl_count_mem #(
        .DEPTH (MAX_NODES)
    ) u_child_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (clear),
        .we      (chl_we),
        .waddr   (chl_waddr),
        .wdata   (chl_wdata),
        .raddr_a (lo_next),
        .raddr_b (hi_next),
        .rval_a  (chl_lo),
        .rval_b  (chl_hi)
    );

    lgpl_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fire),
        .push_data (res),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .full      (full)
    );

    assign from_node           = out_data.from_node;
    assign to_node             = out_data.to_node;
    assign link_out            = out_data.link_out;
    assign edge_added          = out_data.edge_added;
    assign edge_dropped        = out_data.edge_dropped;
    assign target_parent_count = out_data.target_parent_count;
    assign source_child_count  = out_data.source_child_count;
    assign bad_item            = out_data.bad_item;
    assign last_pair           = out_data.last_pair;

endmodule

@@ tb/sv/tb_link_gene_parent_limiter.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_link_gene_parent_limiter
// streams link genes through the parent limiter and checks every result word
// against an in-bench model of the pair walk, the parent limit and the counts;
// directed cases first, then one long output hold-off, then random networks under
// random idling on both sides and a final stretch with no idling
// ----------------------------------------------------------------------------
module tb_link_gene_parent_limiter;
    import lgpl_pkg::*;

    localparam int  NODE_LIMIT   = MAX_NODES_DEF;
    localparam int  LONG_HOLD    = 120;
    localparam int  RANDOM_ITEMS = 860;
    localparam real RUN_LIMIT_NS = 2.0e6;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_write;
    logic [CFG_INDEX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;
    logic                    in_valid;
    logic                    in_stall;
    logic [GENE_W-1:0]       link_value;
    logic                    start_network;
    logic                    out_valid;
    logic                    out_stall;
    logic [NODE_FIELD_W-1:0] from_node;
    logic [NODE_FIELD_W-1:0] to_node;
    logic [GENE_W-1:0]       link_out;
    logic                    edge_added;
    logic                    edge_dropped;
    logic [COUNT_W-1:0]      target_parent_count;
    logic [COUNT_W-1:0]      source_child_count;
    logic                    bad_item;
    logic                    last_pair;

    // model of the block
    logic [CFG_DATA_W-1:0]   node_count_q;
    logic [COUNT_W-1:0]      max_parents_q;
    logic [NODE_FIELD_W-1:0] low_q;
    logic [NODE_FIELD_W-1:0] high_q;
    logic                    past_end_q;
    logic [COUNT_W-1:0]      parent_cnt [NODE_LIMIT];
    logic [COUNT_W-1:0]      child_cnt  [NODE_LIMIT];

    lgpl_result_t pending_results[$];

    int  error_count;
    int  genes_sent;
    bit  idle_on;
    bit  long_hold_req;

    link_gene_parent_limiter dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_write           (cfg_write),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .link_value          (link_value),
        .start_network       (start_network),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .from_node           (from_node),
        .to_node             (to_node),
        .link_out            (link_out),
        .edge_added          (edge_added),
        .edge_dropped        (edge_dropped),
        .target_parent_count (target_parent_count),
        .source_child_count  (source_child_count),
        .bad_item            (bad_item),
        .last_pair           (last_pair)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic void clear_network();
        low_q      = '0;
        high_q     = 5'd1;
        past_end_q = 1'b0;
        for (int i = 0; i < NODE_LIMIT; i++)
        begin
            parent_cnt[i] = '0;
            child_cnt[i]  = '0;
        end
    endfunction

    function automatic int nodes_active();
        int n;
        n = int'(node_count_q);
        if (n < 2) n = 2;
        if (n > NODE_LIMIT) n = NODE_LIMIT;
        return n;
    endfunction

    function automatic lgpl_result_t limit_link(input logic [GENE_W-1:0] gene,
                                                input logic start);
        lgpl_result_t            r;
        int                      n;
        logic [NODE_FIELD_W-1:0] src;
        logic [NODE_FIELD_W-1:0] dst;
        if (start) clear_network();
        n = nodes_active();
        r = '0;
        // off the end of the pair list, or the node count shrank under us
        if (past_end_q || int'(high_q) >= n || low_q >= high_q)
        begin
            past_end_q = 1'b1;
            r.bad_item = 1'b1;
            return r;
        end
        src = low_q;
        dst = high_q;
        if (gene == GENE_BAD)
            r.bad_item = 1'b1;
        else if (gene != GENE_NONE)
        begin
            if (gene == GENE_REV)
            begin
                src = high_q;
                dst = low_q;
            end
            if (max_parents_q != '0 && parent_cnt[dst] >= max_parents_q)
                r.edge_dropped = 1'b1;
            else
            begin
                r.edge_added = 1'b1;
                r.link_out   = gene;
                if (parent_cnt[dst] < COUNT_MAX) parent_cnt[dst] = parent_cnt[dst] + 1'b1;
                if (child_cnt[src] < COUNT_MAX) child_cnt[src] = child_cnt[src] + 1'b1;
            end
        end
        if (int'(high_q) < n - 1)
            high_q = high_q + 1'b1;
        else if (int'(low_q) + 2 >= n)
        begin
            r.last_pair = 1'b1;
            past_end_q  = 1'b1;
        end
        else
        begin
            high_q = low_q + 5'd2;
            low_q  = low_q + 1'b1;
        end
        r.from_node           = src;
        r.to_node             = dst;
        r.target_parent_count = parent_cnt[dst];
        r.source_child_count  = child_cnt[src];
        return r;
    endfunction

    function automatic void expect_result(input lgpl_result_t r);
        pending_results = {pending_results, r};
    endfunction

    // input side: optional idle burst, then hold the word until accepted
    task automatic send_gene(input logic [GENE_W-1:0] gene, input logic start);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid      <= 1'b1;
        link_value    <= gene;
        start_network <= start;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        expect_result(limit_link(gene, start));
        genes_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        in_valid  <= 1'b0;
        wait_drained();
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        if (index == REG_NODE_COUNT)
            node_count_q = data;
        else
            max_parents_q = data[COUNT_W-1:0];
        @(negedge clk);
    endtask

    function automatic logic [GENE_W-1:0] random_gene(input int mode);
        int r;
        r = $urandom_range(0, 15);
        if (mode == 1) return (r < 8) ? GENE_FWD : GENE_REV;
        if (r == 0) return GENE_BAD;
        if (r < 6) return GENE_NONE;
        return (r < 11) ? GENE_FWD : GENE_REV;
    endfunction

    // ---------------------------------------------------------------- tests

    task automatic test_defaults();
        send_gene(GENE_FWD, 1'b1);
        send_gene(GENE_REV, 1'b0);
        send_gene(GENE_NONE, 1'b0);
        send_gene(GENE_BAD, 1'b0);
    endtask

    task automatic test_two_nodes();
        write_reg(REG_NODE_COUNT, 6'd2);
        send_gene(GENE_REV, 1'b1);
        send_gene(GENE_FWD, 1'b0);
        send_gene(GENE_BAD, 1'b1);
    endtask

    task automatic test_parent_limit();
        write_reg(REG_NODE_COUNT, 6'd3);
        write_reg(REG_MAX_PARENTS, 6'd1);
        send_gene(GENE_FWD, 1'b1);
        send_gene(GENE_FWD, 1'b0);
        send_gene(GENE_FWD, 1'b0);
        send_gene(GENE_REV, 1'b1);
        send_gene(GENE_REV, 1'b0);
        send_gene(GENE_REV, 1'b0);
    endtask

    task automatic test_count_clamp();
        write_reg(REG_NODE_COUNT, 6'd0);
        write_reg(REG_MAX_PARENTS, 6'd31);
        send_gene(GENE_FWD, 1'b1);
        write_reg(REG_NODE_COUNT, 6'd1);
        send_gene(GENE_REV, 1'b1);
        write_reg(REG_NODE_COUNT, 6'd63);
        send_gene(GENE_FWD, 1'b1);
    endtask

    task automatic test_shrink_mid_network();
        write_reg(REG_NODE_COUNT, 6'd8);
        write_reg(REG_MAX_PARENTS, 6'd0);
        send_gene(GENE_FWD, 1'b1);
        for (int i = 0; i < 4; i++) send_gene(GENE_REV, 1'b0);
        // current pair (0,6) no longer exists with four nodes
        write_reg(REG_NODE_COUNT, 6'd4);
        send_gene(GENE_FWD, 1'b0);
        send_gene(GENE_FWD, 1'b0);
        send_gene(GENE_NONE, 1'b1);
    endtask

    // every gene leaves or enters the same lower node, filling its child and then its parent count to the top
    task automatic test_full_counts();
        write_reg(REG_NODE_COUNT, 6'd32);
        write_reg(REG_MAX_PARENTS, 6'd0);
        for (int i = 0; i < 31; i++) send_gene(GENE_FWD, i == 0);
        for (int i = 0; i < 31; i++) send_gene(GENE_REV, i == 0);
    endtask

    task automatic test_backpressure();
        write_reg(REG_NODE_COUNT, 6'd12);
        write_reg(REG_MAX_PARENTS, 6'd2);
        long_hold_req = 1'b1;
        for (int i = 0; i < 66; i++) send_gene(random_gene(0), i == 0);
    endtask

    task automatic run_random_network();
        int                    pick;
        int                    n;
        int                    items;
        int                    mode;
        logic [CFG_DATA_W-1:0] count_val;
        logic [CFG_DATA_W-1:0] limit_val;
        logic                  start;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            count_val = CFG_DATA_W'($urandom_range(0, 1));
        else if (pick == 1)
            count_val = CFG_DATA_W'($urandom_range(33, 63));
        else if (pick == 2)
            count_val = 6'd32;
        else
            count_val = CFG_DATA_W'($urandom_range(2, 10));
        pick = $urandom_range(0, 9);
        if (pick < 4)
            limit_val = 6'd0;
        else if (pick == 9)
            limit_val = 6'd31;
        else if (pick == 8)
            limit_val = CFG_DATA_W'($urandom_range(0, 31));
        else
            limit_val = CFG_DATA_W'($urandom_range(1, 3));
        write_reg(REG_NODE_COUNT, count_val);
        write_reg(REG_MAX_PARENTS, limit_val);
        n = nodes_active();
        items = n * (n - 1) / 2;
        mode = ($urandom_range(0, 3) == 0) ? 1 : 0;
        // mostly well-formed: start on the first word, then all pairs
        if ($urandom_range(0, 9) == 0) items = items - $urandom_range(0, items - 1);
        for (int i = 0; i < items; i++)
        begin
            if (i == 0)
                start = ($urandom_range(0, 11) != 0);
            else
                start = ($urandom_range(0, 39) == 0);
            send_gene(random_gene(mode), start);
        end
        repeat ($urandom_range(0, 2)) send_gene(random_gene(0), 1'b0);
    endtask

    task automatic test_random_networks();
        while (genes_sent < RANDOM_ITEMS) run_random_network();
    endtask

    task automatic test_no_idle();
        idle_on = 1'b0;
        write_reg(REG_NODE_COUNT, 6'd16);
        write_reg(REG_MAX_PARENTS, 6'd3);
        for (int i = 0; i < 120; i++) send_gene(random_gene(0), i == 0);
        send_gene(GENE_FWD, 1'b0);
    endtask

    // ---------------------------------------------------------------- output side

    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                out_stall <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(negedge clk);
                out_stall <= 1'b0;
            end
            else
                out_stall <= 1'b0;
        end
    end

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin : check_results
        lgpl_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result word with nothing expected");
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("from_node", want.from_node, from_node);
                check_field("to_node", want.to_node, to_node);
                check_field("link_out", want.link_out, link_out);
                check_field("edge_added", want.edge_added, edge_added);
                check_field("edge_dropped", want.edge_dropped, edge_dropped);
                check_field("target_parent_count", want.target_parent_count,
                            target_parent_count);
                check_field("source_child_count", want.source_child_count,
                            source_child_count);
                check_field("bad_item", want.bad_item, bad_item);
                check_field("last_pair", want.last_pair, last_pair);
            end
        end
    end

    // ---------------------------------------------------------------- main

    initial
    begin
        rst_n         = 1'b0;
        cfg_write     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        link_value    = GENE_NONE;
        start_network = 1'b0;
        error_count   = 0;
        genes_sent    = 0;
        idle_on       = 1'b1;
        long_hold_req = 1'b0;
        node_count_q  = NODE_COUNT_RST;
        max_parents_q = MAX_PARENTS_RST;
        clear_network();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_defaults();
        test_two_nodes();
        test_parent_limit();
        test_count_clamp();
        test_shrink_mid_network();
        test_full_counts();
        test_backpressure();
        test_random_networks();
        test_no_idle();

        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (10) @(negedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
